### rtl/core/spead_header_item_extractor_top_macros.svh
// ----------------------------------------------------------------------------
// SPEAD header item extractor assertion macros
// Concurrent assertion forms used by the result buffer of the block.
// ----------------------------------------------------------------------------
`ifndef SPEAD_HEADER_ITEM_EXTRACTOR_TOP_MACROS_SVH
`define SPEAD_HEADER_ITEM_EXTRACTOR_TOP_MACROS_SVH

// Condition a implies condition b in the same cycle.
`define SPHX_ASSERT_SAME(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("sphx same-cycle check failed");

// Condition a implies condition b in the next cycle.
`define SPHX_ASSERT_NEXT(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("sphx next-cycle check failed");

`endif

### rtl/core/sphx_pkg.sv
// ----------------------------------------------------------------------------
// SPEAD header item extractor package
// Item types, register indexes and constants shared by the block.
// ----------------------------------------------------------------------------
package sphx_pkg;

    localparam int unsigned ID_W    = 23;
    localparam int unsigned VAL_W   = 40;
    localparam int unsigned START_W = 41;
    localparam int unsigned CNT_W   = 16;

    localparam logic [7:0]      MAGIC_BYTE     = 8'h53;
    localparam logic [ID_W-1:0] SIZE_ID_RST    = 23'h000004;
    localparam logic [ID_W-1:0] FRAME_ID_RST   = 23'h001601;
    localparam logic [ID_W-1:0] BAND_ID_RST    = 23'h001700;
    localparam logic [ID_W-1:0] OFFSET_ID_RST  = 23'h001800;
    localparam logic [START_W-1:0] HEADER_BYTES = 41'd8;

    localparam logic [1:0] CFG_SIZE_ID   = 2'd0;
    localparam logic [1:0] CFG_FRAME_ID  = 2'd1;
    localparam logic [1:0] CFG_BAND_ID   = 2'd2;
    localparam logic [1:0] CFG_OFFSET_ID = 2'd3;

    typedef struct packed {
        logic [7:0] packet_byte;
        logic       first_byte;
    } t_in_item;

    typedef struct packed {
        logic               status;
        logic [VAL_W-1:0]   payload_length;
        logic [VAL_W-1:0]   frame_number;
        logic [VAL_W-1:0]   band_mode;
        logic [START_W-1:0] payload_start;
        logic [3:0]         found_mask;
    } t_result;

    typedef struct packed {
        logic    valid;
        t_result res;
    } t_res_push;

endpackage

### rtl/core/sphx_if.sv
// ----------------------------------------------------------------------------
// SPEAD header item extractor channel interfaces
// Valid/ready channels for input bytes and for parse results.
// ----------------------------------------------------------------------------
interface sphx_in_if;
    logic              valid;
    logic              ready;
    sphx_pkg::t_in_item data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface sphx_out_if;
    logic             valid;
    logic             ready;
    sphx_pkg::t_result data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

### rtl/core/sphx_parser.sv
// ----------------------------------------------------------------------------
// SPEAD header parser
// Byte-wise header and item decoding with capture of the configured items.
// ----------------------------------------------------------------------------
module sphx_parser (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [1:0]                    i_cfg_idx,
    input  logic [sphx_pkg::ID_W-1:0]     i_cfg_data,
    input  logic                          i_fire,
    input  sphx_pkg::t_in_item            i_item,
    output sphx_pkg::t_res_push           o_push
);

    localparam logic [1:0] PH_IDLE   = 2'd0;
    localparam logic [1:0] PH_HEADER = 2'd1;
    localparam logic [1:0] PH_ITEMS  = 2'd2;

    logic [1:0]                     r_phase, n_phase;
    logic [2:0]                     r_pos, n_pos;
    logic [sphx_pkg::CNT_W-1:0]     r_total, n_total;
    logic [sphx_pkg::CNT_W-1:0]     r_remain, n_remain;
    logic [sphx_pkg::ID_W-1:0]      r_id, n_id;
    logic [sphx_pkg::VAL_W-1:0]     r_val, n_val;
    logic [sphx_pkg::VAL_W-1:0]     r_len, n_len;
    logic [sphx_pkg::VAL_W-1:0]     r_frame, n_frame;
    logic [sphx_pkg::VAL_W-1:0]     r_band, n_band;
    logic [sphx_pkg::VAL_W-1:0]     r_off, n_off;
    logic [3:0]                     r_seen, n_seen;
    logic [sphx_pkg::ID_W-1:0]      r_size_id, r_frame_id, r_band_id, r_off_id;
    logic                           emit;
    logic                           bad;
    logic [7:0]                     b;

    always_comb begin
        b        = i_item.packet_byte;
        n_phase  = r_phase;
        n_pos    = r_pos;
        n_total  = r_total;
        n_remain = r_remain;
        n_id     = r_id;
        n_val    = r_val;
        n_len    = r_len;
        n_frame  = r_frame;
        n_band   = r_band;
        n_off    = r_off;
        n_seen   = r_seen;
        emit     = 1'b0;
        bad      = 1'b0;
        if (i_fire) begin
            if (i_item.first_byte) begin
                n_pos    = 3'd0;
                n_total  = '0;
                n_remain = '0;
                n_id     = '0;
                n_val    = '0;
                n_len    = '0;
                n_frame  = '0;
                n_band   = '0;
                n_off    = '0;
                n_seen   = '0;
                if (b != sphx_pkg::MAGIC_BYTE) begin
                    n_phase = PH_IDLE;
                    emit    = 1'b1;
                    bad     = 1'b1;
                end else begin
                    n_phase = PH_HEADER;
                    n_pos   = 3'd1;
                end
            end else begin
                case (r_phase)
                    PH_HEADER: begin
                        if (r_pos == 3'd6) begin
                            n_total = {b, 8'h00};
                            n_pos   = 3'd7;
                        end else if (r_pos == 3'd7) begin
                            n_total  = {r_total[15:8], b};
                            n_remain = n_total;
                            n_pos    = 3'd0;
                            if (n_total == '0) begin
                                n_phase = PH_IDLE;
                                emit    = 1'b1;
                            end else begin
                                n_phase = PH_ITEMS;
                            end
                        end else begin
                            n_pos = r_pos + 3'd1;
                        end
                    end
                    PH_ITEMS: begin
                        if (r_pos == 3'd0) begin
                            n_id  = {b[6:0], 16'h0000};
                            n_val = '0;
                        end else if (r_pos <= 3'd2) begin
                            n_id = {r_id[14:0], b};
                        end else begin
                            n_val = {r_val[31:0], b};
                        end
                        if (r_pos == 3'd7) begin
                            if (r_id == r_size_id) begin
                                n_len     = n_val;
                                n_seen[0] = 1'b1;
                            end else if (r_id == r_frame_id) begin
                                n_frame   = n_val;
                                n_seen[1] = 1'b1;
                            end else if (r_id == r_band_id) begin
                                n_band    = n_val;
                                n_seen[2] = 1'b1;
                            end else if (r_id == r_off_id) begin
                                n_off     = n_val;
                                n_seen[3] = 1'b1;
                            end
                            n_pos    = 3'd0;
                            n_remain = r_remain - 16'd1;
                            if (n_remain == '0) begin
                                n_phase = PH_IDLE;
                                emit    = 1'b1;
                            end
                        end else begin
                            n_pos = r_pos + 3'd1;
                        end
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    always_comb begin
        o_push.valid = emit;
        if (bad) begin
            o_push.res        = '0;
            o_push.res.status = 1'b1;
        end else begin
            o_push.res.status         = 1'b0;
            o_push.res.payload_length = n_len;
            o_push.res.frame_number   = n_frame;
            o_push.res.band_mode      = n_band;
            o_push.res.payload_start  = sphx_pkg::HEADER_BYTES
                                      + {22'd0, n_total, 3'd0}
                                      + {1'b0, n_off};
            o_push.res.found_mask     = n_seen;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_IDLE;
            r_pos      <= '0;
            r_total    <= '0;
            r_remain   <= '0;
            r_id       <= '0;
            r_val      <= '0;
            r_len      <= '0;
            r_frame    <= '0;
            r_band     <= '0;
            r_off      <= '0;
            r_seen     <= '0;
            r_size_id  <= sphx_pkg::SIZE_ID_RST;
            r_frame_id <= sphx_pkg::FRAME_ID_RST;
            r_band_id  <= sphx_pkg::BAND_ID_RST;
            r_off_id   <= sphx_pkg::OFFSET_ID_RST;
        end else begin
            r_phase  <= n_phase;
            r_pos    <= n_pos;
            r_total  <= n_total;
            r_remain <= n_remain;
            r_id     <= n_id;
            r_val    <= n_val;
            r_len    <= n_len;
            r_frame  <= n_frame;
            r_band   <= n_band;
            r_off    <= n_off;
            r_seen   <= n_seen;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    sphx_pkg::CFG_SIZE_ID:   r_size_id  <= i_cfg_data;
                    sphx_pkg::CFG_FRAME_ID:  r_frame_id <= i_cfg_data;
                    sphx_pkg::CFG_BAND_ID:   r_band_id  <= i_cfg_data;
                    sphx_pkg::CFG_OFFSET_ID: r_off_id   <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
        end
    end

endmodule

### rtl/core/sphx_out_buf.sv
// ----------------------------------------------------------------------------
// SPEAD header result buffer
// Two-entry result register that decouples the parser from the output stall.
// ----------------------------------------------------------------------------
`include "spead_header_item_extractor_top_macros.svh"

module sphx_out_buf (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  sphx_pkg::t_res_push i_push,
    output logic                o_can_push,
    output logic                o_valid,
    input  logic                i_ready,
    output sphx_pkg::t_result   o_data
);

    logic [1:0]        r_cnt, n_cnt;
    sphx_pkg::t_result r_q0, n_q0;
    sphx_pkg::t_result r_q1, n_q1;
    logic              pop;

    assign pop        = (r_cnt != 2'd0) && i_ready;
    assign o_valid    = (r_cnt != 2'd0);
    assign o_data     = r_q0;
    assign o_can_push = (r_cnt != 2'd2);

    always_comb begin
        n_cnt = r_cnt;
        n_q0  = r_q0;
        n_q1  = r_q1;
        if (pop && i_push.valid) begin
            if (r_cnt == 2'd1) begin
                n_q0 = i_push.res;
            end else begin
                n_q0 = r_q1;
                n_q1 = i_push.res;
            end
        end else if (pop) begin
            n_q0  = r_q1;
            n_cnt = r_cnt - 2'd1;
        end else if (i_push.valid) begin
            if (r_cnt == 2'd0) begin
                n_q0 = i_push.res;
            end else begin
                n_q1 = i_push.res;
            end
            n_cnt = r_cnt + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
        end
        r_q0 <= n_q0;
        r_q1 <= n_q1;
    end

    `SPHX_ASSERT_SAME(a_cnt_range, i_clk, i_rst_n, 1'b1, r_cnt != 2'd3)
    `SPHX_ASSERT_SAME(a_no_push_full, i_clk, i_rst_n, i_push.valid, r_cnt != 2'd2)
    `SPHX_ASSERT_NEXT(a_drain_last, i_clk, i_rst_n, pop && !i_push.valid && r_cnt == 2'd1, r_cnt == 2'd0)

endmodule

### rtl/core/spead_header_item_extractor_top.sv
// ----------------------------------------------------------------------------
// SPEAD header item extractor, top level
// Accepts one packet byte per cycle; a result slot registers each result
// with its completing byte. Input ready drops only while both result slots
// are full. Synchronous active-low reset restores the default item IDs.
// ----------------------------------------------------------------------------
module spead_header_item_extractor_top (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic [1:0]                i_cfg_idx,
    input  logic [sphx_pkg::ID_W-1:0] i_cfg_data,
    sphx_in_if.sink                   i_in,
    sphx_out_if.source                o_out
);

    sphx_pkg::t_res_push push;
    logic                can_push;
    logic                fire;

    assign i_in.ready = can_push;
    assign fire       = i_in.valid && can_push;

    sphx_parser u_parser (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_fire     (fire),
        .i_item     (i_in.data),
        .o_push     (push)
    );

    sphx_out_buf u_out_buf (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .o_can_push (can_push),
        .o_valid    (o_out.valid),
        .i_ready    (o_out.ready),
        .o_data     (o_out.data)
    );

endmodule

### tb/spead_header_item_extractor_top_tb.sv
// ----------------------------------------------------------------------------
// SPEAD header item extractor testbench
// Streams packet bytes through the valid/ready input channel with bursty
// gaps, stalls the result channel, and checks every parsed header result
// against a cycle-free model of the parser kept inside the testbench.
// ----------------------------------------------------------------------------
module spead_header_item_extractor_top_tb;

    localparam logic [1:0] PARSE_IDLE   = 2'd0;
    localparam logic [1:0] PARSE_HEADER = 2'd1;
    localparam logic [1:0] PARSE_ITEMS  = 2'd2;

    logic                       i_clk;
    logic                       i_rst_n;
    logic                       i_cfg_we;
    logic [1:0]                 i_cfg_idx;
    logic [sphx_pkg::ID_W-1:0]  i_cfg_data;

    sphx_in_if  in_ch();
    sphx_out_if out_ch();

    spead_header_item_extractor_top uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in       (in_ch),
        .o_out      (out_ch)
    );

    logic [sphx_pkg::ID_W-1:0]    size_id;
    logic [sphx_pkg::ID_W-1:0]    frame_id;
    logic [sphx_pkg::ID_W-1:0]    band_id;
    logic [sphx_pkg::ID_W-1:0]    offset_id;

    logic [1:0]                   parse_phase;
    logic [2:0]                   byte_pos;
    logic [sphx_pkg::CNT_W-1:0]   item_count;
    logic [sphx_pkg::CNT_W-1:0]   items_left;
    logic [sphx_pkg::ID_W-1:0]    id_shift;
    logic [sphx_pkg::VAL_W-1:0]   value_shift;
    logic [sphx_pkg::VAL_W-1:0]   length_val;
    logic [sphx_pkg::VAL_W-1:0]   frame_val;
    logic [sphx_pkg::VAL_W-1:0]   band_val;
    logic [sphx_pkg::VAL_W-1:0]   offset_val;
    logic [3:0]                   found_bits;

    sphx_pkg::t_result  header_results_due[$];
    int unsigned        error_count;
    int unsigned        bytes_sent;
    int unsigned        burst_left;
    int unsigned        stall_mode;
    int unsigned        stall_left;

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    task automatic report_mismatch(input string what);
        $display("mismatch at %0t: %s", $realtime, what);
        error_count++;
    endtask

    function automatic void clear_packet_state();
        byte_pos    = 3'd0;
        item_count  = '0;
        items_left  = '0;
        id_shift    = '0;
        value_shift = '0;
        length_val  = '0;
        frame_val   = '0;
        band_val    = '0;
        offset_val  = '0;
        found_bits  = '0;
    endfunction

    function automatic void push_header_result(input logic bad_magic);
        sphx_pkg::t_result r;
        r = '0;
        if (bad_magic) begin
            r.status = 1'b1;
        end else begin
            r.payload_length = length_val;
            r.frame_number   = frame_val;
            r.band_mode      = band_val;
            r.payload_start  = sphx_pkg::HEADER_BYTES + {22'd0, item_count, 3'b000}
                             + {1'b0, offset_val};
            r.found_mask     = found_bits;
        end
        header_results_due.push_back(r);
    endfunction

    function automatic void track_header_byte(input logic [7:0] b, input logic first);
        if (first) begin
            clear_packet_state();
            if (b != sphx_pkg::MAGIC_BYTE) begin
                parse_phase = PARSE_IDLE;
                push_header_result(1'b1);
            end else begin
                parse_phase = PARSE_HEADER;
                byte_pos    = 3'd1;
            end
        end else if (parse_phase == PARSE_HEADER) begin
            if (byte_pos == 3'd6) begin
                item_count = {b, 8'h00};
                byte_pos   = 3'd7;
            end else if (byte_pos == 3'd7) begin
                item_count[7:0] = b;
                items_left      = item_count;
                byte_pos        = 3'd0;
                if (item_count == '0) begin
                    parse_phase = PARSE_IDLE;
                    push_header_result(1'b0);
                end else begin
                    parse_phase = PARSE_ITEMS;
                end
            end else begin
                byte_pos = byte_pos + 3'd1;
            end
        end else if (parse_phase == PARSE_ITEMS) begin
            if (byte_pos == 3'd0) begin
                id_shift    = {b[6:0], 16'h0000};
                value_shift = '0;
            end else if (byte_pos <= 3'd2) begin
                id_shift = {id_shift[14:0], b};
            end else begin
                value_shift = {value_shift[31:0], b};
            end
            if (byte_pos == 3'd7) begin
                // Lower registers win when two of them hold the same identifier.
                if (id_shift == size_id) begin
                    length_val = value_shift;
                    found_bits[0] = 1'b1;
                end else if (id_shift == frame_id) begin
                    frame_val = value_shift;
                    found_bits[1] = 1'b1;
                end else if (id_shift == band_id) begin
                    band_val = value_shift;
                    found_bits[2] = 1'b1;
                end else if (id_shift == offset_id) begin
                    offset_val = value_shift;
                    found_bits[3] = 1'b1;
                end
                byte_pos   = 3'd0;
                items_left = items_left - 1'b1;
                if (items_left == '0) begin
                    parse_phase = PARSE_IDLE;
                    push_header_result(1'b0);
                end
            end else begin
                byte_pos = byte_pos + 3'd1;
            end
        end
    endfunction

    task automatic send_byte(input logic [7:0] b, input logic first);
        int unsigned gap;
        if (burst_left == 0) begin
            burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(100, 300)
                                                     : $urandom_range(1, 30);
            gap = $urandom_range(1, 6);
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        burst_left--;
        in_ch.valid <= 1'b1;
        in_ch.data  <= '{packet_byte: b, first_byte: first};
        do @(posedge i_clk); while (!in_ch.ready);
        track_header_byte(b, first);
        bytes_sent++;
    endtask

    task automatic send_packet(input logic [7:0] pk[$], input int unsigned keep);
        for (int unsigned i = 0; i < keep; i++) begin
            send_byte(pk[i], i == 0);
        end
    endtask

    function automatic void push_header(ref logic [7:0] pk[$], input logic [15:0] cnt);
        pk.push_back(sphx_pkg::MAGIC_BYTE);
        repeat (5) pk.push_back(8'($urandom_range(0, 255)));
        pk.push_back(cnt[15:8]);
        pk.push_back(cnt[7:0]);
    endfunction

    function automatic void push_item(ref logic [7:0] pk[$],
                                      input logic [sphx_pkg::ID_W-1:0] id,
                                      input logic [sphx_pkg::VAL_W-1:0] val);
        pk.push_back({1'($urandom_range(0, 1)), id[22:16]});
        pk.push_back(id[15:8]);
        pk.push_back(id[7:0]);
        for (int i = 4; i >= 0; i--) pk.push_back(val[i*8 +: 8]);
    endfunction

    function automatic logic [sphx_pkg::ID_W-1:0] pick_item_id();
        case ($urandom_range(0, 11))
            0, 1:    return size_id;
            2, 3:    return frame_id;
            4, 5:    return band_id;
            6, 7:    return offset_id;
            8:       return '0;
            9:       return '1;
            default: return sphx_pkg::ID_W'($urandom_range(0, 23'h7FFFFF));
        endcase
    endfunction

    function automatic logic [sphx_pkg::VAL_W-1:0] pick_value();
        logic [63:0] r;
        r = {$urandom, $urandom};
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            default: return r[sphx_pkg::VAL_W-1:0];
        endcase
    endfunction

    task automatic random_packet();
        logic [7:0]  pk[$];
        logic [7:0]  b;
        int unsigned kind;
        int unsigned cnt;
        int unsigned keep;
        kind = $urandom_range(0, 99);
        if (kind < 6) begin
            b = 8'($urandom_range(0, 255));
            if (b == sphx_pkg::MAGIC_BYTE) b = ~b;
            send_byte(b, 1'b1);
        end else if (kind < 10) begin
            repeat ($urandom_range(1, 3)) send_byte(8'($urandom_range(0, 255)), 1'b0);
        end else begin
            if (kind < 14) cnt = $urandom_range(0, 65535);
            else if (kind < 24) cnt = $urandom_range(5, 16);
            else cnt = $urandom_range(0, 4);
            push_header(pk, cnt[15:0]);
            for (int unsigned i = 0; i < ((cnt > 20) ? 3 : cnt); i++) begin
                push_item(pk, pick_item_id(), pick_value());
            end
            keep = pk.size();
            if (kind < 14 || $urandom_range(0, 9) == 0) keep = $urandom_range(1, pk.size() - 1);
            send_packet(pk, keep);
        end
    endtask

    task automatic wait_drained();
        in_ch.valid <= 1'b0;
        while (header_results_due.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic go_idle();
        if (parse_phase != PARSE_IDLE) send_byte(8'h00, 1'b1);
        wait_drained();
    endtask

    task automatic load_item_ids(input logic [sphx_pkg::ID_W-1:0] s,
                                 input logic [sphx_pkg::ID_W-1:0] f,
                                 input logic [sphx_pkg::ID_W-1:0] bd,
                                 input logic [sphx_pkg::ID_W-1:0] o);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= sphx_pkg::CFG_SIZE_ID;
        i_cfg_data <= s;
        @(posedge i_clk);
        i_cfg_idx  <= sphx_pkg::CFG_FRAME_ID;
        i_cfg_data <= f;
        @(posedge i_clk);
        i_cfg_idx  <= sphx_pkg::CFG_BAND_ID;
        i_cfg_data <= bd;
        @(posedge i_clk);
        i_cfg_idx  <= sphx_pkg::CFG_OFFSET_ID;
        i_cfg_data <= o;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        size_id   = s;
        frame_id  = f;
        band_id   = bd;
        offset_id = o;
    endtask

    task automatic test_header_cases();
        logic [7:0] pk[$];
        // Stray byte while idle, then bad magic.
        send_byte(8'h12, 1'b0);
        send_byte(8'hFF, 1'b1);
        // A header cut short by a new packet with no items.
        send_byte(sphx_pkg::MAGIC_BYTE, 1'b1);
        send_byte(8'hAA, 1'b0);
        send_byte(8'h55, 1'b0);
        push_header(pk, 16'h0000);
        send_packet(pk, pk.size());
        pk.delete();
        push_header(pk, 16'h0001);
        push_item(pk, offset_id, '1);
        send_packet(pk, pk.size());
        send_byte(8'h00, 1'b1);
        wait_drained();
    endtask

    task automatic test_id_registers();
        logic [7:0] pk[$];
        go_idle();
        load_item_ids('0, '0, '0, '0);
        push_header(pk, 16'd3);
        push_item(pk, '0, 40'h01_2345_6789);
        push_item(pk, '0, 40'hFE_DCBA_9876);
        push_item(pk, 23'd1, '1);
        send_packet(pk, pk.size());
        wait_drained();
        load_item_ids('1, '1, '1, '1);
        pk.delete();
        push_header(pk, 16'd2);
        push_item(pk, '1, '0);
        push_item(pk, '1, '1);
        send_packet(pk, pk.size());
        wait_drained();
        load_item_ids('1, '0, 23'h2AAAAA, 23'h555555);
        pk.delete();
        push_header(pk, 16'd4);
        push_item(pk, 23'h555555, '1);
        push_item(pk, 23'h2AAAAA, pick_value());
        push_item(pk, '0, pick_value());
        push_item(pk, '1, pick_value());
        send_packet(pk, pk.size());
        wait_drained();
    endtask

    task automatic test_random_traffic(input int unsigned budget);
        int unsigned first_count;
        first_count = bytes_sent;
        while (bytes_sent - first_count < budget) random_packet();
        go_idle();
    endtask

    task automatic test_drain_pause();
        load_item_ids(sphx_pkg::SIZE_ID_RST, sphx_pkg::FRAME_ID_RST,
                      sphx_pkg::BAND_ID_RST, sphx_pkg::OFFSET_ID_RST);
        repeat (4) random_packet();
        wait_drained();
        repeat (4) random_packet();
        go_idle();
    endtask

    always @(posedge i_clk) begin : result_side
        sphx_pkg::t_result got;
        sphx_pkg::t_result want;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            got = out_ch.data;
            if (header_results_due.size() == 0) begin
                report_mismatch("result arrived with none expected");
            end else begin
                want = header_results_due.pop_front();
                if (got.status !== want.status)
                    report_mismatch($sformatf("status %0h want %0h", got.status, want.status));
                if (got.payload_length !== want.payload_length)
                    report_mismatch($sformatf("payload_length %0h want %0h",
                                              got.payload_length, want.payload_length));
                if (got.frame_number !== want.frame_number)
                    report_mismatch($sformatf("frame_number %0h want %0h",
                                              got.frame_number, want.frame_number));
                if (got.band_mode !== want.band_mode)
                    report_mismatch($sformatf("band_mode %0h want %0h",
                                              got.band_mode, want.band_mode));
                if (got.payload_start !== want.payload_start)
                    report_mismatch($sformatf("payload_start %0h want %0h",
                                              got.payload_start, want.payload_start));
                if (got.found_mask !== want.found_mask)
                    report_mismatch($sformatf("found_mask %0h want %0h",
                                              got.found_mask, want.found_mask));
            end
        end
        if (stall_left == 0) begin
            stall_mode = $urandom_range(0, 3);
            stall_left = $urandom_range(8, 60);
        end else begin
            stall_left--;
        end
        case (stall_mode)
            0:       out_ch.ready <= 1'b1;
            1:       out_ch.ready <= 1'($urandom_range(0, 1));
            2:       out_ch.ready <= (stall_left[1:0] == 2'd0);
            default: out_ch.ready <= ($urandom_range(0, 7) != 0);
        endcase
    end

    initial begin
        #3_000_000;
        $display("FAIL spead_header_item_extractor_top");
        $finish;
    end

    initial begin
        i_rst_n      = 1'b0;
        i_cfg_we     = 1'b0;
        i_cfg_idx    = sphx_pkg::CFG_SIZE_ID;
        i_cfg_data   = '0;
        in_ch.valid  = 1'b0;
        in_ch.data   = '0;
        out_ch.ready = 1'b0;
        error_count  = 0;
        bytes_sent   = 0;
        burst_left   = 0;
        stall_mode   = 0;
        stall_left   = 0;
        size_id      = sphx_pkg::SIZE_ID_RST;
        frame_id     = sphx_pkg::FRAME_ID_RST;
        band_id      = sphx_pkg::BAND_ID_RST;
        offset_id    = sphx_pkg::OFFSET_ID_RST;
        parse_phase  = PARSE_IDLE;
        clear_packet_state();
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_header_cases();
        test_random_traffic(420);
        test_id_registers();
        load_item_ids(sphx_pkg::ID_W'($urandom_range(0, 23'h7FFFFF)),
                      sphx_pkg::ID_W'($urandom_range(0, 23'h7FFFFF)),
                      sphx_pkg::ID_W'($urandom_range(0, 23'h7FFFFF)),
                      sphx_pkg::ID_W'($urandom_range(0, 23'h7FFFFF)));
        test_random_traffic(380);
        // The band and offset registers share one identifier here.
        begin : shared_id
            logic [sphx_pkg::ID_W-1:0] twin;
            twin = sphx_pkg::ID_W'($urandom_range(0, 23'h7FFFFF));
            load_item_ids(sphx_pkg::ID_W'($urandom_range(0, 23'h7FFFFF)),
                          sphx_pkg::ID_W'($urandom_range(0, 23'h7FFFFF)), twin, twin);
        end
        test_random_traffic(330);
        test_drain_pause();

        wait_drained();
        repeat (8) @(posedge i_clk);
        if (error_count == 0) begin
            $display("PASS spead_header_item_extractor_top");
        end else begin
            $display("FAIL spead_header_item_extractor_top");
        end
        $finish;
    end
endmodule
